@@ rtl/brq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brq_pkg
// Shared constants and operation codes of the framed byte ring queue.
// ----------------------------------------------------------------------------
package brq_pkg;

  // Default build sizes
  localparam int DEF_RING_DEPTH = 256;
  localparam int DEF_MAX_BLOCK  = 8;

  // Field widths fixed by the item format
  localparam int FUNC_W  = 3;
  localparam int LEN_W   = 4;
  localparam int WORD_W  = 64;
  localparam int LEVEL_W = 8;
  localparam int CNT_W   = 16;

  // Width used for count compares, wide enough for any block count
  localparam int CMP_W   = 5;

  localparam logic [CNT_W-1:0] SAT_MAX = 16'hFFFF;

  // Operation codes; code 7 is unused
  typedef enum logic [FUNC_W-1:0] {
    FN_WRITE     = 3'd0,
    FN_WRITE_FRM = 3'd1,
    FN_READ_BLK  = 3'd2,
    FN_READ_BYTE = 3'd3,
    FN_CLEAR     = 3'd4,
    FN_TAKE_SIZE = 3'd5,
    FN_PEEK_SIZE = 3'd6
  } func_e;

endpackage

@@ rtl/brq_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brq_lane
// One byte lane: a memory bank holding every NB-th ring position. Works out
// its own byte offset in the block, write enable and row for both ports.
// ----------------------------------------------------------------------------
module brq_lane
  import brq_pkg::*;
#(
  parameter int NB   = 16,
  parameter int LW   = 4,
  parameter int PW   = 8,
  parameter int LANE = 0
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [PW-1:0]        wr_base_i,
  input  logic [LEN_W-1:0]     wr_cnt_i,
  input  logic [NB-1:0][7:0]   wr_vec_i,
  input  logic [PW-1:0]        rd_base_i,
  output logic [7:0]           rd_byte_o
);

  localparam int RW   = PW - LW;
  localparam int ROWS = 2 ** RW;

  logic [7:0]    mem [ROWS];
  logic [LW-1:0] wr_off;
  logic [LW-1:0] rd_off;
  logic [PW-1:0] wr_pos;
  logic [PW-1:0] rd_pos;
  logic          we;
  logic [7:0]    wbyte;

  // Place this lane within the block at each pointer
  always_comb begin
    wr_off = LW'(LANE) - wr_base_i[LW-1:0];
    rd_off = LW'(LANE) - rd_base_i[LW-1:0];
    wr_pos = wr_base_i + PW'(wr_off);
    rd_pos = rd_base_i + PW'(rd_off);
    we     = wr_en_i && (CMP_W'(wr_off) < CMP_W'(wr_cnt_i));
    wbyte  = wr_vec_i[wr_off];
  end

  // Store the lane byte
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_pos[PW-1:LW]] <= wbyte;
    end
  end

  // Registered read at the read pointer row
  always_ff @(posedge clk_i) begin
    rd_byte_o <= mem[rd_pos[PW-1:LW]];
  end

endmodule

@@ rtl/brq_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brq_merge
// Rotates the lane read bytes back into item order, masks unread bytes and
// picks the byte at the read pointer.
// ----------------------------------------------------------------------------
module brq_merge
  import brq_pkg::*;
#(
  parameter int NB        = 16,
  parameter int LW        = 4,
  parameter int MAX_BLOCK = 8
) (
  input  logic [NB-1:0][7:0] lane_byte_i,
  input  logic [LW-1:0]      rd_low_i,
  input  logic [LEN_W-1:0]   rd_cnt_i,
  output logic [WORD_W-1:0]  read_data_o,
  output logic [7:0]         head_byte_o
);

  // Gather byte j from the lane that held ring position rp+j
  always_comb begin
    read_data_o = '0;
    for (int j = 0; j < MAX_BLOCK; j++) begin
      if (CMP_W'(j) < CMP_W'(rd_cnt_i)) begin
        read_data_o[j*8 +: 8] = lane_byte_i[LW'(rd_low_i + LW'(j))];
      end
    end
    head_byte_o = lane_byte_i[rd_low_i];
  end

endmodule

@@ rtl/byte_ring_queue_framed.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_queue_framed
// Byte ring queue with block, framed and byte access and reject counters.
// ----------------------------------------------------------------------------
// An item is taken at a clock edge with start high and busy low; busy then
// stays high for one cycle and the result is strobed on done_o during the
// cycle that follows, and a new item may start while a result is shown. The
// extra stage comes from the registered read of the lane memories: the bytes
// come back in the cycle after the item is taken, and taking a frame size
// moves the read pointer only once that byte is known. The receiver cannot
// hold a result off; capture it while done_o is high. Storage is split into
// byte lanes, one memory bank per lane, so a whole block is written or read
// in one step. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module byte_ring_queue_framed
  import brq_pkg::*;
#(
  parameter int RING_DEPTH = DEF_RING_DEPTH,
  parameter int MAX_BLOCK  = DEF_MAX_BLOCK
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [FUNC_W-1:0]  func_i,
  input  logic [LEN_W-1:0]   block_len_i,
  input  logic [WORD_W-1:0]  data_word_i,
  output logic               done_o,
  output logic               ok_o,
  output logic [WORD_W-1:0]  read_data_o,
  output logic [7:0]         frame_size_o,
  output logic [LEVEL_W-1:0] used_bytes_o,
  output logic [LEVEL_W-1:0] free_bytes_o,
  output logic [CNT_W-1:0]   full_rejects_o,
  output logic [CNT_W-1:0]   empty_rejects_o
);

  localparam int NB  = 2 ** $clog2(MAX_BLOCK + 1);
  localparam int LW  = $clog2(NB);
  localparam int DW  = $clog2(RING_DEPTH);
  localparam int PW  = (DW > LW + 1) ? DW : LW + 1;
  localparam int CW  = (PW > CMP_W) ? PW : CMP_W;
  localparam logic [PW-1:0] FULL_LVL = PW'(RING_DEPTH - 1);

  // Pointers and counters
  logic [PW-1:0]    wp_q, rp_q;
  logic [CNT_W-1:0] full_cnt_q, empty_cnt_q;

  // Stage between accept and result
  logic             stg_q;
  logic             stg_ok_q;
  logic [LEN_W-1:0] stg_rd_cnt_q;
  logic [LW-1:0]    stg_rd_low_q;
  logic             stg_fs_q;
  logic             stg_take_q;

  // Result registers
  logic               done_q, ok_q;
  logic [WORD_W-1:0]  read_data_q;
  logic [7:0]         frame_size_q;
  logic [LEVEL_W-1:0] used_q, free_q;

  // Decode signals
  func_e              fn;
  logic               accept;
  logic [LEN_W-1:0]   len_c, need_c, rd_n_c;
  logic [PW-1:0]      used_c, free_c;
  logic               fits_c, avail_c, nonempty_c;
  logic               wr_en;
  logic [NB-1:0][7:0] wr_vec;

  // Lane outputs and merge results
  logic [NB-1:0][7:0] lane_byte;
  logic [WORD_W-1:0]  merge_data;
  logic [7:0]         head_byte;
  logic               take_mv;
  logic [PW-1:0]      used_n;
  logic [PW-1:0]      free_n;

  assign busy   = stg_q;
  assign accept = start && !busy;
  assign fn     = func_e'(func_i);

  // Decode the operation and check space and fill
  always_comb begin
    len_c      = (block_len_i > LEN_W'(MAX_BLOCK)) ? LEN_W'(MAX_BLOCK) : block_len_i;
    need_c     = len_c + ((fn == FN_WRITE_FRM) ? LEN_W'(1) : LEN_W'(0));
    rd_n_c     = (fn == FN_READ_BYTE) ? LEN_W'(1) : len_c;
    used_c     = wp_q - rp_q;
    free_c     = FULL_LVL - used_c;
    fits_c     = CW'(free_c) >= CW'(need_c);
    avail_c    = CW'(used_c) >= CW'(rd_n_c);
    nonempty_c = used_c != '0;
    wr_en      = accept && ((fn == FN_WRITE) || (fn == FN_WRITE_FRM)) && fits_c;
  end

  // Assemble the write bytes, length byte first for a framed write
  always_comb begin
    wr_vec = '0;
    if (fn == FN_WRITE_FRM) begin
      wr_vec[0] = 8'(len_c);
      for (int j = 0; j < MAX_BLOCK; j++) begin
        wr_vec[j+1] = data_word_i[j*8 +: 8];
      end
    end else begin
      for (int j = 0; j < MAX_BLOCK; j++) begin
        wr_vec[j] = data_word_i[j*8 +: 8];
      end
    end
  end

  // Memory lanes
  for (genvar k = 0; k < NB; k++) begin : g_lane
    brq_lane #(
      .NB   (NB),
      .LW   (LW),
      .PW   (PW),
      .LANE (k)
    ) u_lane (
      .clk_i     (clk_i),
      .wr_en_i   (wr_en),
      .wr_base_i (wp_q),
      .wr_cnt_i  (need_c),
      .wr_vec_i  (wr_vec),
      .rd_base_i (rp_q),
      .rd_byte_o (lane_byte[k])
    );
  end

  // Merge lane bytes into item order
  brq_merge #(
    .NB        (NB),
    .LW        (LW),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_merge (
    .lane_byte_i (lane_byte),
    .rd_low_i    (stg_rd_low_q),
    .rd_cnt_i    (stg_rd_cnt_q),
    .read_data_o (merge_data),
    .head_byte_o (head_byte)
  );

  // Levels after the item, including a frame-size take
  always_comb begin
    take_mv = stg_take_q && (head_byte != 8'h00);
    used_n  = wp_q - rp_q - (take_mv ? PW'(1) : PW'(0));
    free_n  = FULL_LVL - used_n;
  end

  // Carry out the item on accept, finish a take once the head byte is back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q         <= '0;
      rp_q         <= '0;
      full_cnt_q   <= '0;
      empty_cnt_q  <= '0;
      stg_q        <= 1'b0;
      stg_ok_q     <= 1'b0;
      stg_rd_cnt_q <= '0;
      stg_rd_low_q <= '0;
      stg_fs_q     <= 1'b0;
      stg_take_q   <= 1'b0;
    end else if (accept) begin
      stg_q        <= 1'b1;
      stg_ok_q     <= 1'b0;
      stg_rd_cnt_q <= '0;
      stg_rd_low_q <= rp_q[LW-1:0];
      stg_fs_q     <= 1'b0;
      stg_take_q   <= 1'b0;
      case (fn)
        FN_WRITE, FN_WRITE_FRM: begin
          if (fits_c) begin
            wp_q     <= wp_q + PW'(need_c);
            stg_ok_q <= 1'b1;
          end else if (full_cnt_q != SAT_MAX) begin
            full_cnt_q <= full_cnt_q + CNT_W'(1);
          end
        end
        FN_READ_BLK, FN_READ_BYTE: begin
          if (avail_c) begin
            rp_q         <= rp_q + PW'(rd_n_c);
            stg_ok_q     <= 1'b1;
            stg_rd_cnt_q <= rd_n_c;
          end else if (empty_cnt_q != SAT_MAX) begin
            empty_cnt_q <= empty_cnt_q + CNT_W'(1);
          end
        end
        FN_CLEAR: begin
          wp_q     <= rp_q;
          stg_ok_q <= 1'b1;
        end
        FN_TAKE_SIZE, FN_PEEK_SIZE: begin
          stg_ok_q   <= nonempty_c;
          stg_fs_q   <= nonempty_c;
          stg_take_q <= nonempty_c && (fn == FN_TAKE_SIZE);
        end
        default: begin
        end
      endcase
    end else begin
      stg_q <= 1'b0;
      if (take_mv) begin
        rp_q <= rp_q + PW'(1);
      end
      stg_take_q <= 1'b0;
    end
  end

  // Hold the result for its strobe cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= stg_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_q) begin
      ok_q         <= stg_ok_q;
      read_data_q  <= merge_data;
      frame_size_q <= stg_fs_q ? head_byte : 8'h00;
      used_q       <= LEVEL_W'(used_n);
      free_q       <= LEVEL_W'(free_n);
    end
  end

  assign done_o          = done_q;
  assign ok_o            = ok_q;
  assign read_data_o     = read_data_q;
  assign frame_size_o    = frame_size_q;
  assign used_bytes_o    = used_q;
  assign free_bytes_o    = free_q;
  assign full_rejects_o  = full_cnt_q;
  assign empty_rejects_o = empty_cnt_q;

  // Every accepted item yields exactly one strobe
  a_stage_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_q |=> done_q)
    else $error("accepted item produced no result strobe");

  // Stage and result strobe never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stg_q && done_q))
    else $error("stage busy during result strobe");

  // Fill never exceeds ring capacity
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wp_q - rp_q) <= FULL_LVL)
    else $error("ring fill beyond capacity");

  // A rejected item returns no data
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !ok_q) |-> (read_data_q == '0 && frame_size_q == 8'h00))
    else $error("rejected item returned data");

endmodule
